FILE: rtl/core/isc_pkg.sv
package isc_pkg;

	// Default table shape
	localparam int SLOTS_DEF    = 4;
	localparam int REF_BITS_DEF = 8;

	// Fixed field widths of the request and result ports
	localparam int INODE_W  = 32;
	localparam int REL_W    = 2;
	localparam int IDX_OUT_W = 2;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 8;

	// Request commands
	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_PUT = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_PUT_FREE  = 2'd2;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;  // latch request and search results
		logic commit;   // update slot table and load result register
	} dp_cmd_t;

endpackage

FILE: rtl/core/refcounted_inode_slot_cache.sv
// Flow: the accepting edge latches the request together with the search over all
// slots, which is combinational in the accept cycle. In the commit state the
// table is updated and the result register loaded, which raises out_valid. No
// new request is taken until the last one has been committed.
// A waiting result stalls the update until it is taken.
// Reset (arst_n low): every slot holds inode number 0 with count 0.
module refcounted_inode_slot_cache #(
	parameter int SLOTS    = isc_pkg::SLOTS_DEF,
	parameter int REF_BITS = isc_pkg::REF_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            command,
	input  logic [isc_pkg::INODE_W-1:0]     inode_number,
	input  logic [isc_pkg::REL_W-1:0]       release_slot,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [isc_pkg::IDX_OUT_W-1:0]   slot_index,
	output logic                            was_hit,
	output logic                            needs_load,
	output logic [isc_pkg::STATUS_W-1:0]    status,
	output logic [isc_pkg::COUNT_W-1:0]     ref_count
);

	isc_pkg::dp_cmd_t dp_cmd;

	// Sequence request capture and commit
	isc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (dp_cmd)
	);

	// Hold the slot table and the result register
	isc_dpath #(
		.SLOTS    (SLOTS),
		.REF_BITS (REF_BITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (dp_cmd),
		.command      (command),
		.inode_number (inode_number),
		.release_slot (release_slot),
		.slot_index   (slot_index),
		.was_hit      (was_hit),
		.needs_load   (needs_load),
		.status       (status),
		.ref_count    (ref_count)
	);

endmodule

FILE: rtl/core/isc_ctrl.sv
module isc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output isc_pkg::dp_cmd_t  cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_COMMIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   commit_go;

	// Take a request only while no request is in flight
	assign in_ready  = (state_q == ST_IDLE);
	assign commit_go = (state_q == ST_COMMIT) && (!out_valid_q || out_ready);

	assign cmd.capture = in_valid && in_ready;
	assign cmd.commit  = commit_go;
	assign out_valid   = out_valid_q;

	// Advance state and hold the result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					if (commit_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (commit_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/core/isc_dpath.sv
module isc_dpath #(
	parameter int SLOTS    = isc_pkg::SLOTS_DEF,
	parameter int REF_BITS = isc_pkg::REF_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  isc_pkg::dp_cmd_t                cmd,
	input  logic                            command,
	input  logic [isc_pkg::INODE_W-1:0]     inode_number,
	input  logic [isc_pkg::REL_W-1:0]       release_slot,
	output logic [isc_pkg::IDX_OUT_W-1:0]   slot_index,
	output logic                            was_hit,
	output logic                            needs_load,
	output logic [isc_pkg::STATUS_W-1:0]    status,
	output logic [isc_pkg::COUNT_W-1:0]     ref_count
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};
	localparam logic [REF_BITS-1:0] REF_ONE = REF_BITS'(1);

	// Slot table
	logic [isc_pkg::INODE_W-1:0] slot_inode_q [SLOTS];
	logic [REF_BITS-1:0]         slot_refs_q  [SLOTS];

	// Search results
	logic [SLOTS-1:0] match;
	logic [SLOTS-1:0] idle;
	logic [IDX_W-1:0] hit_idx;
	logic [IDX_W-1:0] free_idx;

	// Captured request and search results
	logic                        cmd_s1;
	logic [isc_pkg::INODE_W-1:0] inode_s1;
	logic [isc_pkg::REL_W-1:0]   rel_s1;
	logic                        hit_s1;
	logic [IDX_W-1:0]            hit_idx_s1;
	logic                        free_s1;
	logic [IDX_W-1:0]            free_idx_s1;

	// Commit logic
	logic [31:0]                 rel_ext;
	logic                        rel_ok;
	logic [IDX_W-1:0]            sel_idx;
	logic [REF_BITS-1:0]         sel_refs;
	logic                        wr_en;
	logic                        wr_inode;
	logic [REF_BITS-1:0]         new_refs;
	logic [IDX_W-1:0]            res_idx;
	logic [REF_BITS-1:0]         res_count;
	logic                        res_hit;
	logic                        res_load;
	logic [isc_pkg::STATUS_W-1:0] res_status;
	logic [31:0]                 res_idx_ext;
	logic [31:0]                 res_count_ext;

	// Compare every slot against the request
	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			match[i] = (slot_inode_q[i] == inode_number);
			idle[i]  = (slot_refs_q[i] == '0);
		end
	end

	// Pick the lowest matching and the lowest idle slot
	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_idx = IDX_W'(i);
			end
			if (idle[i]) begin
				free_idx = IDX_W'(i);
			end
		end
	end

	// Latch request and search results
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_s1      <= command;
			inode_s1    <= inode_number;
			rel_s1      <= release_slot;
			hit_s1      <= |match;
			hit_idx_s1  <= hit_idx;
			free_s1     <= |idle;
			free_idx_s1 <= free_idx;
		end
	end

	// Work out the slot update and the result
	always_comb begin
		rel_ext = 32'(rel_s1);
		rel_ok  = (rel_ext < 32'(SLOTS));
		if (cmd_s1 == isc_pkg::CMD_PUT) begin
			sel_idx = rel_ext[IDX_W-1:0];
		end else if (hit_s1) begin
			sel_idx = hit_idx_s1;
		end else begin
			sel_idx = free_idx_s1;
		end
		sel_refs   = slot_refs_q[sel_idx];
		wr_en      = 1'b0;
		wr_inode   = 1'b0;
		new_refs   = sel_refs;
		res_idx    = sel_idx;
		res_count  = '0;
		res_hit    = 1'b0;
		res_load   = 1'b0;
		res_status = isc_pkg::ST_OK;
		if (cmd_s1 == isc_pkg::CMD_PUT) begin
			if (!rel_ok || sel_refs == '0) begin
				res_status = isc_pkg::ST_PUT_FREE;
			end else begin
				wr_en     = 1'b1;
				new_refs  = sel_refs - REF_ONE;
				res_count = new_refs;
			end
		end else if (hit_s1) begin
			wr_en     = 1'b1;
			new_refs  = (sel_refs == REF_MAX) ? sel_refs : sel_refs + REF_ONE;
			res_count = new_refs;
			res_hit   = 1'b1;
		end else if (free_s1) begin
			wr_en     = 1'b1;
			wr_inode  = 1'b1;
			new_refs  = REF_ONE;
			res_count = REF_ONE;
			res_load  = 1'b1;
		end else begin
			res_idx    = '0;
			res_status = isc_pkg::ST_FULL;
		end
		res_idx_ext   = 32'(res_idx);
		res_count_ext = 32'(res_count);
	end

	// Update the slot table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				slot_inode_q[i] <= '0;
				slot_refs_q[i]  <= '0;
			end
		end else if (cmd.commit && wr_en) begin
			slot_refs_q[sel_idx] <= new_refs;
			if (wr_inode) begin
				slot_inode_q[sel_idx] <= inode_s1;
			end
		end
	end

	// Load the result register; the put result echoes the requested slot
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (cmd_s1 == isc_pkg::CMD_PUT) begin
				slot_index <= rel_s1;
			end else begin
				slot_index <= res_idx_ext[isc_pkg::IDX_OUT_W-1:0];
			end
			was_hit    <= res_hit;
			needs_load <= res_load;
			status     <= res_status;
			ref_count  <= res_count_ext[isc_pkg::COUNT_W-1:0];
		end
	end

endmodule
